@@ src/boot_region_allocator_unit_macros.svh @@
`ifndef BOOT_REGION_ALLOCATOR_UNIT_MACROS_SVH
`define BOOT_REGION_ALLOCATOR_UNIT_MACROS_SVH

// Implication checked in the same cycle.
`define BRA_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define BRA_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/bra_pkg.sv @@
package bra_pkg;

    localparam int USABLE_ENTRIES_DEF   = 32;
    localparam int RESERVED_ENTRIES_DEF = 64;
    localparam int ADDR_BITS_DEF        = 32;

    typedef enum logic [2:0] {
        FN_ADD         = 3'd0,
        FN_RESERVE     = 3'd1,
        FN_ALLOC       = 3'd2,
        FN_RD_USABLE   = 3'd3,
        FN_RD_RESERVED = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_OVF   = 3'd2,
        ST_NOFIT = 3'd3,
        ST_IDX   = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_MRD,
        S_MEV,
        S_MFL,
        S_URD,
        S_UEV,
        S_RRD,
        S_REV,
        S_IT1,
        S_IT2,
        S_TAIL,
        S_TT1,
        S_TT2,
        S_FOUND,
        S_EEV,
        S_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_SETST,
        OP_MINIT_IN,
        OP_MINIT_FOUND,
        OP_MRD,
        OP_MEV,
        OP_MFLUSH,
        OP_MFIN,
        OP_SINIT,
        OP_URD,
        OP_UEV,
        OP_RRD,
        OP_REV,
        OP_T1,
        OP_T2I,
        OP_T2T,
        OP_TAIL,
        OP_ERD,
        OP_EEV,
        OP_LOAD
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t st;
    } bra_cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       len_zero;
        logic       addr_ovf;
        logic       tbl_full;
        logic       alloc_bad;
        logic       idx_ok;
        logic       mrd_end;
        logic       fl_done;
        logic       u_end;
        logic       u_skip;
        logic       r_end;
        logic       r_skip;
        logic       r_break;
        logic       r_try;
        logic       try_ok;
        logic       res_full;
        logic       tail_ok;
    } bra_sts_t;

endpackage

@@ src/bra_ctrl.sv @@
module bra_ctrl
    import bra_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  bra_sts_t sts,
    output bra_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.op == OP_LOAD) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_CHECK;
            end
            S_CHECK: begin
                case (sts.func)
                    FN_ADD, FN_RESERVE: begin
                        if (sts.len_zero || sts.addr_ovf || sts.tbl_full) state_next = S_DONE;
                        else state_next = S_MRD;
                    end
                    FN_ALLOC: begin
                        state_next = sts.alloc_bad ? S_DONE : S_URD;
                    end
                    FN_RD_USABLE, FN_RD_RESERVED: begin
                        state_next = sts.idx_ok ? S_EEV : S_DONE;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_MRD:   state_next = sts.mrd_end ? S_MFL : S_MEV;
            S_MEV:   state_next = S_MRD;
            S_MFL: begin
                if (sts.fl_done) state_next = S_DONE;
            end
            S_URD:   state_next = sts.u_end ? S_DONE : S_UEV;
            S_UEV:   state_next = sts.u_skip ? S_URD : S_RRD;
            S_RRD:   state_next = sts.r_end ? S_TAIL : S_REV;
            S_REV: begin
                if (sts.r_skip) state_next = S_RRD;
                else if (sts.r_break) state_next = S_TAIL;
                else if (sts.r_try) state_next = S_IT1;
                else state_next = S_RRD;
            end
            S_IT1:   state_next = S_IT2;
            S_IT2:   state_next = sts.try_ok ? S_FOUND : S_RRD;
            S_TAIL:  state_next = sts.tail_ok ? S_TT1 : S_URD;
            S_TT1:   state_next = S_TT2;
            S_TT2:   state_next = sts.try_ok ? S_FOUND : S_URD;
            S_FOUND: state_next = sts.res_full ? S_DONE : S_MRD;
            S_EEV:   state_next = S_DONE;
            S_DONE: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd.op = OP_NONE;
        cmd.st = ST_OK;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) cmd.op = OP_CAPTURE;
            end
            S_CHECK: begin
                case (sts.func)
                    FN_ADD, FN_RESERVE: begin
                        if (sts.len_zero) begin
                            cmd.op = OP_SETST;
                            cmd.st = ST_OK;
                        end else if (sts.addr_ovf) begin
                            cmd.op = OP_SETST;
                            cmd.st = ST_OVF;
                        end else if (sts.tbl_full) begin
                            cmd.op = OP_SETST;
                            cmd.st = ST_FULL;
                        end else begin
                            cmd.op = OP_MINIT_IN;
                        end
                    end
                    FN_ALLOC: begin
                        if (sts.alloc_bad) begin
                            cmd.op = OP_SETST;
                            cmd.st = ST_NOFIT;
                        end else begin
                            cmd.op = OP_SINIT;
                        end
                    end
                    FN_RD_USABLE, FN_RD_RESERVED: begin
                        if (sts.idx_ok) begin
                            cmd.op = OP_ERD;
                        end else begin
                            cmd.op = OP_SETST;
                            cmd.st = ST_IDX;
                        end
                    end
                    default: begin
                        cmd.op = OP_SETST;
                        cmd.st = ST_NOFIT;
                    end
                endcase
            end
            S_MRD: begin
                if (!sts.mrd_end) cmd.op = OP_MRD;
            end
            S_MEV:   cmd.op = OP_MEV;
            S_MFL:   cmd.op = sts.fl_done ? OP_MFIN : OP_MFLUSH;
            S_URD: begin
                if (sts.u_end) begin
                    cmd.op = OP_SETST;
                    cmd.st = ST_NOFIT;
                end else begin
                    cmd.op = OP_URD;
                end
            end
            S_UEV:   cmd.op = OP_UEV;
            S_RRD: begin
                if (!sts.r_end) cmd.op = OP_RRD;
            end
            S_REV:   cmd.op = OP_REV;
            S_IT1:   cmd.op = OP_T1;
            S_IT2:   cmd.op = OP_T2I;
            S_TAIL:  cmd.op = OP_TAIL;
            S_TT1:   cmd.op = OP_T1;
            S_TT2:   cmd.op = OP_T2T;
            S_FOUND: begin
                if (sts.res_full) begin
                    cmd.op = OP_SETST;
                    cmd.st = ST_FULL;
                end else begin
                    cmd.op = OP_MINIT_FOUND;
                end
            end
            S_EEV:   cmd.op = OP_EEV;
            S_DONE: begin
                if (out_free) cmd.op = OP_LOAD;
            end
            default: cmd.op = OP_NONE;
        endcase
    end

endmodule

@@ src/bra_datapath.sv @@
module bra_datapath
    import bra_pkg::*;
#(
    parameter int USABLE_ENTRIES   = USABLE_ENTRIES_DEF,
    parameter int RESERVED_ENTRIES = RESERVED_ENTRIES_DEF,
    parameter int ADDR_BITS        = ADDR_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  bra_cmd_t    cmd,
    output bra_sts_t    sts,
    input  logic [2:0]  in_func,
    input  logic [31:0] in_addr,
    input  logic [31:0] in_length,
    input  logic [31:0] in_alignment,
    input  logic [31:0] in_window_low,
    input  logic [31:0] in_window_high,
    input  logic [5:0]  in_entry_index,
    output logic [2:0]  out_status,
    output logic [31:0] out_alloc_base,
    output logic [31:0] out_entry_base,
    output logic [31:0] out_entry_size,
    output logic [6:0]  out_entry_count
);

    localparam int AW  = ADDR_BITS;
    localparam int EW  = 2 * AW;
    localparam int UIW = $clog2(USABLE_ENTRIES);
    localparam int RIW = $clog2(RESERVED_ENTRIES);
    localparam int UCW = $clog2(USABLE_ENTRIES + 1);
    localparam int RCW = $clog2(RESERVED_ENTRIES + 1);
    localparam int KW  = (UCW > RCW) ? UCW : RCW;
    localparam int CW  = ((AW > 32) ? AW : 32) + 1;

    // tables: each word holds {size, base}
    logic [EW-1:0] u_mem [USABLE_ENTRIES];
    logic [EW-1:0] r_mem [RESERVED_ENTRIES];
    logic [EW-1:0] u_rd_reg, r_rd_reg;
    logic [UIW-1:0] u_raddr;
    logic [RIW-1:0] r_raddr;

    logic [UCW-1:0] ucount_reg;
    logic [RCW-1:0] rcount_reg;

    logic [2:0]    func_reg;
    logic [AW-1:0] addr_reg, len_reg, lo_reg, hi_reg;
    logic [31:0]   al_reg;
    logic [5:0]    idx_reg;

    logic [AW-1:0] nb_reg, ne_reg, cb_reg, cs_reg;
    logic          cv_reg, emit_reg;
    logic [KW-1:0] k_reg, w_reg;

    logic [UCW-1:0] mi_reg;
    logic [RCW-1:0] ri_reg;
    logic [AW-1:0]  cur_reg, we_reg, gend_reg, pend_reg, found_reg, fend_reg;
    logic [CW-1:0]  cand_reg;

    logic [2:0]    res_status_reg;
    logic [AW-1:0] res_abase_reg, res_eb_reg, res_es_reg;

    logic [2:0]  m_status_reg;
    logic [31:0] m_abase_reg, m_eb_reg, m_es_reg;
    logic [6:0]  m_cnt_reg;

    logic          sel_res;
    logic [EW-1:0] rd;
    logic [AW-1:0] eb, es, ee;
    logic          e_before, e_after;
    logic [KW-1:0] n_sel;
    logic [AW:0]   add_sum;

    logic [AW-1:0] ub, ue, wb_c, we_c, rb, re;
    logic [31:0]   alm1;
    logic [CW-1:0] cand_c;
    logic [AW:0]   cend;

    logic          wr_en;
    logic [AW-1:0] wr_base, wr_size;

    assign sel_res = (func_reg == FN_RESERVE) || (func_reg == FN_ALLOC)
                  || (func_reg == FN_RD_RESERVED);
    assign rd      = sel_res ? r_rd_reg : u_rd_reg;
    assign eb      = rd[AW-1:0];
    assign es      = rd[EW-1:AW];
    assign ee      = eb + es;
    assign n_sel   = sel_res ? KW'(rcount_reg) : KW'(ucount_reg);
    assign add_sum = {1'b0, addr_reg} + {1'b0, len_reg};

    // entry strictly before (not touching) or strictly after the pending range
    assign e_before = !emit_reg && (ee < nb_reg);
    assign e_after  = !emit_reg && (eb > ne_reg);

    assign ub   = u_rd_reg[AW-1:0];
    assign ue   = u_rd_reg[AW-1:0] + u_rd_reg[EW-1:AW];
    assign wb_c = (ub > lo_reg) ? ub : lo_reg;
    assign we_c = ((hi_reg != '0) && (hi_reg < ue)) ? hi_reg : ue;
    assign rb   = r_rd_reg[AW-1:0];
    assign re   = r_rd_reg[AW-1:0] + r_rd_reg[EW-1:AW];

    assign alm1   = al_reg - 32'd1;
    assign cand_c = (CW'(cur_reg) + CW'(alm1)) & ~CW'(alm1);
    assign cend   = {1'b0, cand_reg[AW-1:0]} + {1'b0, len_reg};

    always_comb begin
        sts.func      = func_reg;
        sts.len_zero  = (len_reg == '0);
        sts.addr_ovf  = add_sum[AW];
        sts.tbl_full  = sel_res ? (rcount_reg >= RCW'(RESERVED_ENTRIES))
                                : (ucount_reg >= UCW'(USABLE_ENTRIES));
        sts.alloc_bad = (len_reg == '0) || ((al_reg & alm1) != 32'd0)
                     || ((hi_reg != '0) && (hi_reg <= lo_reg));
        sts.idx_ok    = (func_reg == FN_RD_USABLE) ? (32'(idx_reg) < 32'(ucount_reg))
                                                   : (32'(idx_reg) < 32'(rcount_reg));
        sts.mrd_end   = (k_reg == n_sel);
        sts.fl_done   = !cv_reg && emit_reg;
        sts.u_end     = (mi_reg == ucount_reg);
        sts.u_skip    = (we_c <= wb_c);
        sts.r_end     = (ri_reg == rcount_reg);
        sts.r_skip    = (re <= cur_reg);
        sts.r_break   = (rb >= we_reg);
        sts.r_try     = (rb > cur_reg);
        sts.try_ok    = (cand_reg[CW-1:AW] == '0) && !cend[AW]
                     && (cend[AW-1:0] <= gend_reg);
        sts.res_full  = (rcount_reg >= RCW'(RESERVED_ENTRIES));
        sts.tail_ok   = (cur_reg < we_reg);
    end

    // table write for the in-place merge: carry first, then entry or new range
    always_comb begin
        wr_en   = 1'b0;
        wr_base = eb;
        wr_size = es;
        case (cmd.op)
            OP_MEV: begin
                if (cv_reg) begin
                    wr_en   = 1'b1;
                    wr_base = cb_reg;
                    wr_size = cs_reg;
                end else if (e_before || emit_reg) begin
                    wr_en = 1'b1;
                end else if (e_after) begin
                    wr_en   = 1'b1;
                    wr_base = nb_reg;
                    wr_size = ne_reg - nb_reg;
                end
            end
            OP_MFLUSH: begin
                if (cv_reg) begin
                    wr_en   = 1'b1;
                    wr_base = cb_reg;
                    wr_size = cs_reg;
                end else if (!emit_reg) begin
                    wr_en   = 1'b1;
                    wr_base = nb_reg;
                    wr_size = ne_reg - nb_reg;
                end
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_comb begin
        case (cmd.op)
            OP_MRD:  u_raddr = UIW'(k_reg);
            OP_ERD:  u_raddr = UIW'(idx_reg);
            default: u_raddr = UIW'(mi_reg);
        endcase
        case (cmd.op)
            OP_MRD:  r_raddr = RIW'(k_reg);
            OP_ERD:  r_raddr = RIW'(idx_reg);
            default: r_raddr = RIW'(ri_reg);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en && !sel_res) u_mem[UIW'(w_reg)] <= {wr_size, wr_base};
        u_rd_reg <= u_mem[u_raddr];
    end

    always_ff @(posedge aclk) begin
        if (wr_en && sel_res) r_mem[RIW'(w_reg)] <= {wr_size, wr_base};
        r_rd_reg <= r_mem[r_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ucount_reg <= '0;
            rcount_reg <= '0;
        end else if (cmd.op == OP_MFIN) begin
            if (sel_res) rcount_reg <= RCW'(w_reg);
            else ucount_reg <= UCW'(w_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) w_reg <= w_reg + KW'(1);
        case (cmd.op)
            OP_CAPTURE: begin
                func_reg       <= in_func;
                addr_reg       <= AW'(in_addr);
                len_reg        <= AW'(in_length);
                al_reg         <= (in_alignment == 32'd0) ? 32'd1 : in_alignment;
                lo_reg         <= AW'(in_window_low);
                hi_reg         <= AW'(in_window_high);
                idx_reg        <= in_entry_index;
                res_status_reg <= ST_OK;
                res_abase_reg  <= '0;
                res_eb_reg     <= '0;
                res_es_reg     <= '0;
            end
            OP_SETST: res_status_reg <= cmd.st;
            OP_MINIT_IN, OP_MINIT_FOUND: begin
                nb_reg   <= (cmd.op == OP_MINIT_IN) ? addr_reg : found_reg;
                ne_reg   <= (cmd.op == OP_MINIT_IN) ? add_sum[AW-1:0] : fend_reg;
                k_reg    <= '0;
                w_reg    <= '0;
                cv_reg   <= 1'b0;
                emit_reg <= 1'b0;
            end
            OP_MEV: begin
                k_reg <= k_reg + KW'(1);
                if (cv_reg) begin
                    cb_reg <= eb;
                    cs_reg <= es;
                end else if (e_before || emit_reg) begin
                    cv_reg <= 1'b0;
                end else if (e_after) begin
                    cb_reg   <= eb;
                    cs_reg   <= es;
                    cv_reg   <= 1'b1;
                    emit_reg <= 1'b1;
                end else begin
                    nb_reg <= (eb < nb_reg) ? eb : nb_reg;
                    ne_reg <= (ee > ne_reg) ? ee : ne_reg;
                end
            end
            OP_MFLUSH: begin
                if (cv_reg) begin
                    if (!emit_reg) begin
                        cb_reg   <= nb_reg;
                        cs_reg   <= ne_reg - nb_reg;
                        emit_reg <= 1'b1;
                    end else begin
                        cv_reg <= 1'b0;
                    end
                end else begin
                    emit_reg <= 1'b1;
                end
            end
            OP_MFIN: begin
                if (func_reg == FN_ALLOC) res_abase_reg <= found_reg;
            end
            OP_SINIT: mi_reg <= '0;
            OP_UEV: begin
                if (sts.u_skip) begin
                    mi_reg <= mi_reg + UCW'(1);
                end else begin
                    cur_reg <= wb_c;
                    we_reg  <= we_c;
                    ri_reg  <= '0;
                end
            end
            OP_REV: begin
                if (sts.r_skip) begin
                    ri_reg <= ri_reg + RCW'(1);
                end else if (sts.r_break) begin
                    ri_reg <= ri_reg;
                end else if (sts.r_try) begin
                    gend_reg <= rb;
                    pend_reg <= re;
                end else begin
                    cur_reg <= re;
                    ri_reg  <= ri_reg + RCW'(1);
                end
            end
            OP_T1: cand_reg <= cand_c;
            OP_T2I, OP_T2T: begin
                if (sts.try_ok) begin
                    found_reg <= cand_reg[AW-1:0];
                    fend_reg  <= cend[AW-1:0];
                end else if (cmd.op == OP_T2I) begin
                    cur_reg <= pend_reg;
                    ri_reg  <= ri_reg + RCW'(1);
                end else begin
                    mi_reg <= mi_reg + UCW'(1);
                end
            end
            OP_TAIL: begin
                if (sts.tail_ok) gend_reg <= we_reg;
                else mi_reg <= mi_reg + UCW'(1);
            end
            OP_EEV: begin
                res_eb_reg <= eb;
                res_es_reg <= es;
            end
            OP_LOAD: begin
                m_status_reg <= res_status_reg;
                m_abase_reg  <= 32'(res_abase_reg);
                m_eb_reg     <= 32'(res_eb_reg);
                m_es_reg     <= 32'(res_es_reg);
                case (func_reg)
                    FN_ADD, FN_RD_USABLE:              m_cnt_reg <= 7'(ucount_reg);
                    FN_RESERVE, FN_ALLOC, FN_RD_RESERVED: m_cnt_reg <= 7'(rcount_reg);
                    default:                           m_cnt_reg <= '0;
                endcase
            end
            default: cur_reg <= cur_reg;
        endcase
    end

    assign out_status      = m_status_reg;
    assign out_alloc_base  = m_abase_reg;
    assign out_entry_base  = m_eb_reg;
    assign out_entry_size  = m_es_reg;
    assign out_entry_count = m_cnt_reg;

endmodule

@@ src/boot_region_allocator_unit.sv @@
// One item at a time. Add and reserve merge the range by a walk of that table
// that reads each entry and then writes it back. Allocate walks the usable entries
// in turn, rescanning the reserved table for each usable entry and trying each gap
// it finds there. The next item is taken once a result is in the output register.
// Synchronous reset clears both counts; no clearing pass.
`include "boot_region_allocator_unit_macros.svh"

module boot_region_allocator_unit
    import bra_pkg::*;
#(
    parameter int USABLE_ENTRIES   = USABLE_ENTRIES_DEF,
    parameter int RESERVED_ENTRIES = RESERVED_ENTRIES_DEF,
    parameter int ADDR_BITS        = ADDR_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // addr, length, alignment, window_low, window_high, entry_index, zero pad
    input  logic [167:0] s_tdata,
    // func
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // alloc_base, entry_base, entry_size, entry_count, zero pad
    output logic [103:0] m_tdata,
    // status
    output logic [2:0]   m_tuser
);

    bra_cmd_t    cmd;
    bra_sts_t    sts;
    logic [31:0] alloc_base, entry_base, entry_size;
    logic [6:0]  entry_count;

    bra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bra_datapath #(
        .USABLE_ENTRIES   (USABLE_ENTRIES),
        .RESERVED_ENTRIES (RESERVED_ENTRIES),
        .ADDR_BITS        (ADDR_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .in_func         (s_tuser),
        .in_addr         (s_tdata[31:0]),
        .in_length       (s_tdata[63:32]),
        .in_alignment    (s_tdata[95:64]),
        .in_window_low   (s_tdata[127:96]),
        .in_window_high  (s_tdata[159:128]),
        .in_entry_index  (s_tdata[165:160]),
        .out_status      (m_tuser),
        .out_alloc_base  (alloc_base),
        .out_entry_base  (entry_base),
        .out_entry_size  (entry_size),
        .out_entry_count (entry_count)
    );

    assign m_tdata = {1'b0, entry_count, entry_size, entry_base, alloc_base};

    `BRA_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "item taken while busy")
    `BRA_ASSERT_IMP(a_abase_only_ok, m_tvalid && (m_tuser != ST_OK), m_tdata[31:0] == 32'd0, "alloc base on failure")
    `BRA_ASSERT_IMP(a_entry_zero_bad_idx, m_tvalid && (m_tuser == ST_IDX), m_tdata[95:32] == 64'd0, "entry on bad index")

endmodule
